>>> hdl/tgp_pkg.sv
// Shared types, widths, codes and tables for the tile grid ray door probe.
// No dependencies; every other file of the block imports this package.
package tgp_pkg;

    // field widths
    localparam int POS_W    = 19;
    localparam int ANGLE_W  = 12;
    localparam int DR_W     = 12;
    localparam int DIST_W   = 40;
    localparam int CELL_W   = 5;
    localparam int KIND_W   = 2;
    localparam int SQ_W     = 2 * POS_W;

    // map geometry: 64-unit tiles in 11.8 fixed point span 2^14
    localparam int SPAN_LOG  = 14;
    localparam int FRAC_BITS = 8;
    localparam int ADDR_W    = 2 * CELL_W;
    localparam int MAP_DEPTH = 1 << ADDR_W;
    localparam int TILE_W    = KIND_W + 1;

    // march coordinates carry sign and a full tangent step
    localparam int MAR_W = 34;

    // CORDIC
    localparam int CO_W         = 33;
    localparam int Z_W          = 25;
    localparam int ATAN_W       = 23;
    localparam int CSTEP_W      = 4;
    localparam int QUARTER_BITS = 22;
    localparam int TURN_PAD     = QUARTER_BITS - (ANGLE_W - 2);
    localparam logic [CO_W-1:0] CORDIC_GAIN = 33'd652032874;
    localparam logic [CO_W-1:0] UNIT_ONE    = 33'd1073741824;
    localparam logic [CSTEP_W-1:0] CORDIC_LAST = 4'd15;

    localparam logic [ANGLE_W-1:0] ANG_QUARTER = 12'd1024;
    localparam logic [ANGLE_W-1:0] ANG_HALF    = 12'd2048;
    localparam logic [ANGLE_W-1:0] ANG_3Q      = 12'd3072;

    // divider: dividend 48 bits, divisor 32 bits, quotient 31 bits
    localparam int DIV_N_W  = 48;
    localparam int DIV_D_W  = 32;
    localparam int DIV_Q_W  = 31;
    localparam int DIV_HI_W = DIV_N_W - DIV_Q_W;
    localparam int DCNT_W   = 5;
    localparam logic [DIV_Q_W-1:0] TAN_SAT = 31'h7FFF_FFFF;

    localparam logic [DR_W-1:0] DOOR_RANGE_RST = 12'd128;

    // tile kinds
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DOOR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
    localparam logic [OP_W-1:0] OP_MAP_WR  = 5'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 5'd2;
    localparam logic [OP_W-1:0] OP_LOAD    = 5'd3;
    localparam logic [OP_W-1:0] OP_CORDIC  = 5'd4;
    localparam logic [OP_W-1:0] OP_TAN_GO  = 5'd5;
    localparam logic [OP_W-1:0] OP_TAN_END = 5'd6;
    localparam logic [OP_W-1:0] OP_HX_GO   = 5'd7;
    localparam logic [OP_W-1:0] OP_HX_END  = 5'd8;
    localparam logic [OP_W-1:0] OP_HS_GO   = 5'd9;
    localparam logic [OP_W-1:0] OP_HS_END  = 5'd10;
    localparam logic [OP_W-1:0] OP_H_HIT   = 5'd11;
    localparam logic [OP_W-1:0] OP_V_HIT   = 5'd12;
    localparam logic [OP_W-1:0] OP_STEP    = 5'd13;
    localparam logic [OP_W-1:0] OP_SQ      = 5'd14;
    localparam logic [OP_W-1:0] OP_SUM_H   = 5'd15;
    localparam logic [OP_W-1:0] OP_SUM_V   = 5'd16;
    localparam logic [OP_W-1:0] OP_V_SETUP = 5'd17;
    localparam logic [OP_W-1:0] OP_FIN     = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] idx;
    } tgp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic tan_zero;
        logic tan_sat;
        logic in_map;
        logic solid;
    } tgp_stat_t;

    // arctangent of 2^-i in 2^-24 turn
    function automatic logic [ATAN_W-1:0] atan_turn(input logic [CSTEP_W-1:0] i);
        logic [ATAN_W-1:0] v;
        unique case (i)
            4'd0:  v = 23'd2097152;
            4'd1:  v = 23'd1238021;
            4'd2:  v = 23'd654136;
            4'd3:  v = 23'd332050;
            4'd4:  v = 23'd166669;
            4'd5:  v = 23'd83416;
            4'd6:  v = 23'd41718;
            4'd7:  v = 23'd20860;
            4'd8:  v = 23'd10430;
            4'd9:  v = 23'd5215;
            4'd10: v = 23'd2608;
            4'd11: v = 23'd1304;
            4'd12: v = 23'd652;
            4'd13: v = 23'd326;
            4'd14: v = 23'd163;
            4'd15: v = 23'd81;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/tile_grid_ray_door_probe.sv
// Top level of the tile grid ray door probe: controller plus datapath.
// Depends on tgp_pkg, tgp_ctrl, tgp_datapath (and tgp_divider below it).
//
//   channel   handshake          payload
//   s_        s_valid/s_ready    action, cell_col/row/kind, door_valid, pos_x/y, angle
//   m_        m_valid/m_ready    hit, hit_x/y, dist_sq, from_horizontal, at_door, door_col/row
//   cfg       cfg_wen            cfg_wdata (door_range)
//
// A map write is taken in idle and written to the map as it is accepted. A cast runs
// 16 CORDIC steps and a serial tangent division, then, unless the tangent is zero, two
// more divisions and a horizontal march; a vertical march follows unless it saturated.
// After reset the map is cleared one cell a cycle, all 1024 cells; s_ready stays low.
// The result register holds a finished cast while the next item is taken; a cast
// that finishes while the result still waits stalls until m_ready.
module tile_grid_ray_door_probe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [tgp_pkg::CELL_W-1:0]    s_cell_col,
    input  logic [tgp_pkg::CELL_W-1:0]    s_cell_row,
    input  logic [tgp_pkg::KIND_W-1:0]    s_cell_kind,
    input  logic                          s_door_valid,
    input  logic [tgp_pkg::POS_W-1:0]     s_pos_x,
    input  logic [tgp_pkg::POS_W-1:0]     s_pos_y,
    input  logic [tgp_pkg::ANGLE_W-1:0]   s_angle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [tgp_pkg::POS_W-1:0]     m_hit_x,
    output logic [tgp_pkg::POS_W-1:0]     m_hit_y,
    output logic [tgp_pkg::DIST_W-1:0]    m_dist_sq,
    output logic                          m_from_horizontal,
    output logic                          m_at_door,
    output logic [tgp_pkg::CELL_W-1:0]    m_door_col,
    output logic [tgp_pkg::CELL_W-1:0]    m_door_row,
    input  logic                          cfg_wen,
    input  logic [tgp_pkg::DR_W-1:0]      cfg_wdata
);
    import tgp_pkg::*;

    tgp_cmd_t  cmd;
    tgp_stat_t stat;

    tgp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    tgp_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_cell_col        (s_cell_col),
        .s_cell_row        (s_cell_row),
        .s_cell_kind       (s_cell_kind),
        .s_door_valid      (s_door_valid),
        .s_pos_x           (s_pos_x),
        .s_pos_y           (s_pos_y),
        .s_angle           (s_angle),
        .cfg_wen           (cfg_wen),
        .cfg_wdata         (cfg_wdata),
        .m_hit             (m_hit),
        .m_hit_x           (m_hit_x),
        .m_hit_y           (m_hit_y),
        .m_dist_sq         (m_dist_sq),
        .m_from_horizontal (m_from_horizontal),
        .m_at_door         (m_at_door),
        .m_door_col        (m_door_col),
        .m_door_row        (m_door_row)
    );

endmodule

>>> hdl/tgp_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the tangent and march setup.
// Depends on tgp_pkg for widths.
module tgp_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [tgp_pkg::DIV_N_W-1:0]  dividend,
    input  logic [tgp_pkg::DIV_D_W-1:0]  divisor,
    output logic                         busy,
    output logic [tgp_pkg::DIV_Q_W-1:0]  quotient
);
    import tgp_pkg::*;

    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_Q_W-1:0] low_reg, low_next;
    logic [DIV_Q_W-1:0] quot_reg, quot_next;
    logic [DIV_D_W-1:0] dvs_reg, dvs_next;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [DIV_D_W:0]   shifted;
    logic               ge;

    // high part of the dividend must already be below the divisor
    assign shifted = {rem_reg, low_reg[DIV_Q_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = {{(DIV_D_W-DIV_HI_W){1'b0}}, dividend[DIV_N_W-1:DIV_Q_W]};
            low_next  = dividend[DIV_Q_W-1:0];
            dvs_next  = divisor;
            cnt_next  = DCNT_W'(DIV_Q_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? DIV_D_W'(shifted - {1'b0, dvs_reg}) : shifted[DIV_D_W-1:0];
            low_next  = {low_reg[DIV_Q_W-2:0], 1'b0};
            quot_next = {quot_reg[DIV_Q_W-2:0], ge};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

>>> hdl/tgp_datapath.sv
// Datapath: tile map memory, CORDIC, tangent, grid marches, distances and result registers.
// Depends on tgp_pkg and tgp_divider; driven by tgp_ctrl through a command struct.
module tgp_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tgp_pkg::tgp_cmd_t             cmd,
    output tgp_pkg::tgp_stat_t            stat,
    input  logic [tgp_pkg::CELL_W-1:0]    s_cell_col,
    input  logic [tgp_pkg::CELL_W-1:0]    s_cell_row,
    input  logic [tgp_pkg::KIND_W-1:0]    s_cell_kind,
    input  logic                          s_door_valid,
    input  logic [tgp_pkg::POS_W-1:0]     s_pos_x,
    input  logic [tgp_pkg::POS_W-1:0]     s_pos_y,
    input  logic [tgp_pkg::ANGLE_W-1:0]   s_angle,
    input  logic                          cfg_wen,
    input  logic [tgp_pkg::DR_W-1:0]      cfg_wdata,
    output logic                          m_hit,
    output logic [tgp_pkg::POS_W-1:0]     m_hit_x,
    output logic [tgp_pkg::POS_W-1:0]     m_hit_y,
    output logic [tgp_pkg::DIST_W-1:0]    m_dist_sq,
    output logic                          m_from_horizontal,
    output logic                          m_at_door,
    output logic [tgp_pkg::CELL_W-1:0]    m_door_col,
    output logic [tgp_pkg::CELL_W-1:0]    m_door_row
);
    import tgp_pkg::*;

    localparam logic signed [MAR_W-1:0] SPAN = MAR_W'(1 << SPAN_LOG);
    localparam logic signed [MAR_W-1:0] UNIT = MAR_W'(1 << FRAC_BITS);
    localparam logic [DIV_N_W-1:0] STEP_NUM = DIV_N_W'(64'd1 << 30);

    // tile map
    logic [TILE_W-1:0] map_mem [MAP_DEPTH];
    logic [TILE_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [TILE_W-1:0] wdata;
    logic              wen;
    logic [KIND_W-1:0] kind_in;

    // cast state
    logic [POS_W-1:0]          px_reg, py_reg;
    logic [ANGLE_W-1:0]        ang_reg;
    logic                      rzero_reg, up_reg, right_reg;
    logic signed [CO_W-1:0]    x_reg, y_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic                      tneg_reg, presat_reg, sat_reg, qneg_reg;
    logic [DIV_Q_W-1:0]        tmag_reg;
    logic signed [MAR_W-1:0]   xi_reg, yi_reg, xs_reg, ys_reg;
    logic                      hok_reg, vok_reg, hdoor_reg, vdoor_reg;
    logic [POS_W-1:0]          hx_reg, hy_reg, vx_reg, vy_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;
    logic [DIST_W-1:0]         hd_reg, vd_reg;
    logic [DR_W-1:0]           door_range_reg;

    // divider hookup
    logic               div_start, div_busy;
    logic [DIV_N_W-1:0] div_n;
    logic [DIV_D_W-1:0] div_d;
    logic [DIV_Q_W-1:0] div_q;

    // quadrant fold and magnitudes
    logic signed [CO_W-1:0] cos_v, sin_v, cos_neg, sin_neg;
    logic [DIV_D_W-1:0]     cmag, smag;
    logic                   presat;

    // CORDIC step
    logic [CSTEP_W-1:0]     cstep;
    logic signed [CO_W-1:0] x_sh, y_sh;
    logic signed [Z_W-1:0]  atan_v;

    // march setup
    logic signed [MAR_W-1:0] px_s, py_s, yb, xb, q_s, tq_s, pv_s;
    logic [SPAN_LOG:0]       hmag, vmag;
    logic [SPAN_LOG+DIV_Q_W:0] vprod;
    logic                    yneg;

    // distance
    logic [POS_W:0]   dxw, dyw, dxn, dyn;
    logic [POS_W-1:0] dxm, dym;

    // final choice
    logic                  use_h, any_hit, door_hit;
    logic [POS_W-1:0]      ex, ey;
    logic [DIST_W-1:0]     dsel, dlim;
    logic [2*DR_W-1:0]     dr_sq;
    logic                  sat_now;

    tgp_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // ---- map memory ----
    assign kind_in = (s_cell_kind == KIND_BAD) ? KIND_EMPTY : s_cell_kind;
    assign wen     = (cmd.op == OP_CLEAR) || (cmd.op == OP_MAP_WR);
    assign waddr   = (cmd.op == OP_CLEAR) ? cmd.idx : {s_cell_row, s_cell_col};
    assign wdata   = (cmd.op == OP_CLEAR) ? TILE_W'(0) : {s_door_valid, kind_in};
    assign raddr   = {yi_reg[POS_W-1:SPAN_LOG], xi_reg[POS_W-1:SPAN_LOG]};

    always_ff @(posedge aclk) begin
        if (wen) begin
            map_mem[waddr] <= wdata;
        end
        rdata_reg <= map_mem[raddr];
    end

    // ---- trig ----
    always_comb begin
        unique case (ang_reg[ANGLE_W-1 -: 2])
            2'd0: begin cos_v = x_reg;  sin_v = y_reg;  end
            2'd1: begin cos_v = -y_reg; sin_v = x_reg;  end
            2'd2: begin cos_v = -x_reg; sin_v = -y_reg; end
            2'd3: begin cos_v = y_reg;  sin_v = -x_reg; end
        endcase
    end

    assign cos_neg = -cos_v;
    assign sin_neg = -sin_v;
    assign cmag    = cos_v[CO_W-1] ? cos_neg[DIV_D_W-1:0] : cos_v[DIV_D_W-1:0];
    assign smag    = sin_v[CO_W-1] ? sin_neg[DIV_D_W-1:0] : sin_v[DIV_D_W-1:0];
    // quotient would reach 2^31 or cos is zero
    assign presat  = (cmag == '0) ||
                     ({16'b0, smag} >= {1'b0, cmag, 15'b0});

    assign cstep  = cmd.idx[CSTEP_W-1:0];
    assign x_sh   = x_reg >>> cstep;
    assign y_sh   = y_reg >>> cstep;
    assign atan_v = $signed({{(Z_W-ATAN_W){1'b0}}, atan_turn(cstep)});

    // ---- march setup ----
    assign px_s = $signed({{(MAR_W-POS_W){1'b0}}, px_reg});
    assign py_s = $signed({{(MAR_W-POS_W){1'b0}}, py_reg});
    assign yb   = $signed({{(MAR_W-POS_W){1'b0}}, py_reg[POS_W-1:SPAN_LOG],
                           {SPAN_LOG{1'b0}}});
    assign xb   = $signed({{(MAR_W-POS_W){1'b0}}, px_reg[POS_W-1:SPAN_LOG],
                           {SPAN_LOG{1'b0}}});
    assign hmag = up_reg ? {1'b0, py_reg[SPAN_LOG-1:0]}
                         : (SPAN_LOG+1)'((1 << SPAN_LOG) - py_reg[SPAN_LOG-1:0]);
    assign vmag = right_reg ? (SPAN_LOG+1)'((1 << SPAN_LOG) - px_reg[SPAN_LOG-1:0])
                            : {1'b0, px_reg[SPAN_LOG-1:0]};
    assign q_s   = $signed({{(MAR_W-DIV_Q_W){1'b0}}, div_q});
    assign tq_s  = $signed({{(MAR_W-DIV_Q_W+2){1'b0}}, tmag_reg[DIV_Q_W-1:2]});
    assign vprod = vmag * tmag_reg;
    assign pv_s  = $signed({{(MAR_W-(SPAN_LOG+DIV_Q_W+1-16)){1'b0}},
                            vprod[SPAN_LOG+DIV_Q_W:16]});
    assign yneg  = (!right_reg) ^ tneg_reg;

    always_comb begin
        div_start = 1'b0;
        div_n     = '0;
        div_d     = {1'b0, tmag_reg};
        unique case (cmd.op)
            OP_TAN_GO: begin
                div_start = 1'b1;
                div_n     = {smag, 16'b0};
                div_d     = cmag;
            end
            OP_HX_GO: begin
                div_start = 1'b1;
                div_n     = {{(DIV_N_W-SPAN_LOG-17){1'b0}}, hmag, 16'b0};
            end
            OP_HS_GO: begin
                div_start = 1'b1;
                div_n     = STEP_NUM;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // ---- distance ----
    assign dxw = {1'b0, xi_reg[POS_W-1:0]} - {1'b0, px_reg};
    assign dyw = {1'b0, yi_reg[POS_W-1:0]} - {1'b0, py_reg};
    assign dxn = -dxw;
    assign dyn = -dyw;
    assign dxm = dxw[POS_W] ? dxn[POS_W-1:0] : dxw[POS_W-1:0];
    assign dym = dyw[POS_W] ? dyn[POS_W-1:0] : dyw[POS_W-1:0];

    // ---- final choice ----
    assign any_hit  = hok_reg || vok_reg;
    assign use_h    = hok_reg && (!vok_reg || (hd_reg < vd_reg));
    assign ex       = use_h ? hx_reg : vx_reg;
    assign ey       = use_h ? hy_reg : vy_reg;
    assign dsel     = use_h ? hd_reg : vd_reg;
    assign dr_sq    = door_range_reg * door_range_reg;
    assign dlim     = {dr_sq, {(2*FRAC_BITS){1'b0}}};
    assign door_hit = (use_h ? hdoor_reg : vdoor_reg) && (dsel < dlim);
    assign sat_now  = presat_reg || (div_q == TAN_SAT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            door_range_reg <= DOOR_RANGE_RST;
        end else if (cfg_wen) begin
            door_range_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                px_reg    <= s_pos_x;
                py_reg    <= s_pos_y;
                ang_reg   <= s_angle;
                rzero_reg <= (s_angle[ANGLE_W-3:0] == '0);
                up_reg    <= s_angle > ANG_HALF;
                right_reg <= (s_angle > ANG_3Q) || (s_angle < ANG_QUARTER);
                x_reg     <= (s_angle[ANGLE_W-3:0] == '0) ? UNIT_ONE : CORDIC_GAIN;
                y_reg     <= '0;
                z_reg     <= $signed({{(Z_W-QUARTER_BITS){1'b0}},
                                      s_angle[ANGLE_W-3:0], {TURN_PAD{1'b0}}});
                hok_reg   <= 1'b0;
                vok_reg   <= 1'b0;
            end
            OP_CORDIC: begin
                // on an axis the unit vector is exact; hold it
                if (!rzero_reg) begin
                    if (!z_reg[Z_W-1]) begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        z_reg <= z_reg - atan_v;
                    end else begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        z_reg <= z_reg + atan_v;
                    end
                end
            end
            OP_TAN_GO: begin
                tneg_reg   <= sin_v[CO_W-1] != cos_v[CO_W-1];
                presat_reg <= presat;
            end
            OP_TAN_END: begin
                sat_reg  <= sat_now;
                tmag_reg <= sat_now ? TAN_SAT : div_q;
            end
            OP_HX_GO: begin
                qneg_reg <= up_reg ^ tneg_reg;
                yi_reg   <= up_reg ? (yb - UNIT) : (yb + SPAN);
                ys_reg   <= up_reg ? -SPAN : SPAN;
            end
            OP_HX_END: begin
                xi_reg <= qneg_reg ? (px_s - q_s) : (px_s + q_s);
            end
            OP_HS_END: begin
                xs_reg <= right_reg ? q_s : -q_s;
            end
            OP_V_SETUP: begin
                xi_reg <= right_reg ? (xb + SPAN) : (xb - UNIT);
                xs_reg <= right_reg ? SPAN : -SPAN;
                yi_reg <= yneg ? (py_s - pv_s) : (py_s + pv_s);
                ys_reg <= up_reg ? -tq_s : tq_s;
            end
            OP_STEP: begin
                xi_reg <= xi_reg + xs_reg;
                yi_reg <= yi_reg + ys_reg;
            end
            OP_H_HIT: begin
                hok_reg   <= 1'b1;
                hx_reg    <= xi_reg[POS_W-1:0];
                hy_reg    <= yi_reg[POS_W-1:0];
                hdoor_reg <= (rdata_reg[KIND_W-1:0] == KIND_DOOR) && rdata_reg[KIND_W];
            end
            OP_V_HIT: begin
                vok_reg   <= 1'b1;
                vx_reg    <= xi_reg[POS_W-1:0];
                vy_reg    <= yi_reg[POS_W-1:0];
                vdoor_reg <= (rdata_reg[KIND_W-1:0] == KIND_DOOR) && rdata_reg[KIND_W];
            end
            OP_SQ: begin
                sqx_reg <= dxm * dxm;
                sqy_reg <= dym * dym;
            end
            OP_SUM_H: begin
                hd_reg <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
            end
            OP_SUM_V: begin
                vd_reg <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
            end
            OP_FIN: begin
                m_hit             <= any_hit;
                m_hit_x           <= any_hit ? ex : '0;
                m_hit_y           <= any_hit ? ey : '0;
                m_dist_sq         <= any_hit ? dsel : '0;
                m_from_horizontal <= any_hit && use_h;
                m_at_door         <= any_hit && door_hit;
                m_door_col        <= (any_hit && door_hit) ? ex[POS_W-1:SPAN_LOG] : '0;
                m_door_row        <= (any_hit && door_hit) ? ey[POS_W-1:SPAN_LOG] : '0;
            end
            default: begin
                tmag_reg <= tmag_reg;
            end
        endcase
    end

    assign stat.div_busy = div_busy;
    assign stat.tan_zero = (tmag_reg == '0);
    assign stat.tan_sat  = sat_reg;
    assign stat.in_map   = (xi_reg[MAR_W-1:POS_W] == '0) && (yi_reg[MAR_W-1:POS_W] == '0);
    assign stat.solid    = (rdata_reg[KIND_W-1:0] == KIND_WALL) ||
                           (rdata_reg[KIND_W-1:0] == KIND_DOOR);

endmodule

>>> hdl/tgp_ctrl.sv
// Controller state machine: sequences map clear, casts and the result handshake.
// Depends on tgp_pkg; drives tgp_datapath through the command struct.
module tgp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    output logic                m_valid,
    input  logic                m_ready,
    output tgp_pkg::tgp_cmd_t   cmd,
    input  tgp_pkg::tgp_stat_t  stat
);
    import tgp_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] ST_CLEAR    = 5'd0;
    localparam logic [ST_W-1:0] ST_IDLE     = 5'd1;
    localparam logic [ST_W-1:0] ST_CORDIC   = 5'd2;
    localparam logic [ST_W-1:0] ST_TAN_GO   = 5'd3;
    localparam logic [ST_W-1:0] ST_TAN_WAIT = 5'd4;
    localparam logic [ST_W-1:0] ST_H_GO     = 5'd5;
    localparam logic [ST_W-1:0] ST_H_WAIT   = 5'd6;
    localparam logic [ST_W-1:0] ST_HS_GO    = 5'd7;
    localparam logic [ST_W-1:0] ST_HS_WAIT  = 5'd8;
    localparam logic [ST_W-1:0] ST_H_CHK    = 5'd9;
    localparam logic [ST_W-1:0] ST_H_TEST   = 5'd10;
    localparam logic [ST_W-1:0] ST_H_SQ     = 5'd11;
    localparam logic [ST_W-1:0] ST_H_SUM    = 5'd12;
    localparam logic [ST_W-1:0] ST_V_GO     = 5'd13;
    localparam logic [ST_W-1:0] ST_V_CHK    = 5'd14;
    localparam logic [ST_W-1:0] ST_V_TEST   = 5'd15;
    localparam logic [ST_W-1:0] ST_V_SQ     = 5'd16;
    localparam logic [ST_W-1:0] ST_V_SUM    = 5'd17;
    localparam logic [ST_W-1:0] ST_FIN      = 5'd18;

    logic [ST_W-1:0]   state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              ovalid_reg, ovalid_next;
    logic              out_free;

    assign out_free = !ovalid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.op      = OP_NONE;
        cmd.idx     = cnt_reg;
        s_ready     = 1'b0;
        ovalid_next = ovalid_reg && !m_ready;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op   = OP_CLEAR;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(MAP_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action) begin
                        cmd.op     = OP_LOAD;
                        cnt_next   = '0;
                        state_next = ST_CORDIC;
                    end else begin
                        cmd.op = OP_MAP_WR;
                    end
                end
            end
            ST_CORDIC: begin
                cmd.op = OP_CORDIC;
                if (cnt_reg[CSTEP_W-1:0] == CORDIC_LAST) begin
                    state_next = ST_TAN_GO;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_TAN_GO: begin
                cmd.op     = OP_TAN_GO;
                state_next = ST_TAN_WAIT;
            end
            ST_TAN_WAIT: begin
                if (!stat.div_busy) begin
                    cmd.op     = OP_TAN_END;
                    state_next = ST_H_GO;
                end
            end
            ST_H_GO: begin
                // flat ray never meets a horizontal line
                if (stat.tan_zero) begin
                    state_next = ST_V_GO;
                end else begin
                    cmd.op     = OP_HX_GO;
                    state_next = ST_H_WAIT;
                end
            end
            ST_H_WAIT: begin
                if (!stat.div_busy) begin
                    cmd.op     = OP_HX_END;
                    state_next = ST_HS_GO;
                end
            end
            ST_HS_GO: begin
                cmd.op     = OP_HS_GO;
                state_next = ST_HS_WAIT;
            end
            ST_HS_WAIT: begin
                if (!stat.div_busy) begin
                    cmd.op     = OP_HS_END;
                    state_next = ST_H_CHK;
                end
            end
            ST_H_CHK: begin
                state_next = stat.in_map ? ST_H_TEST : ST_V_GO;
            end
            ST_H_TEST: begin
                if (stat.solid) begin
                    cmd.op     = OP_H_HIT;
                    state_next = ST_H_SQ;
                end else begin
                    cmd.op     = OP_STEP;
                    state_next = ST_H_CHK;
                end
            end
            ST_H_SQ: begin
                cmd.op     = OP_SQ;
                state_next = ST_H_SUM;
            end
            ST_H_SUM: begin
                cmd.op     = OP_SUM_H;
                state_next = ST_V_GO;
            end
            ST_V_GO: begin
                // steep ray with saturated tangent skips the vertical march
                if (stat.tan_sat) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.op     = OP_V_SETUP;
                    state_next = ST_V_CHK;
                end
            end
            ST_V_CHK: begin
                state_next = stat.in_map ? ST_V_TEST : ST_FIN;
            end
            ST_V_TEST: begin
                if (stat.solid) begin
                    cmd.op     = OP_V_HIT;
                    state_next = ST_V_SQ;
                end else begin
                    cmd.op     = OP_STEP;
                    state_next = ST_V_CHK;
                end
            end
            ST_V_SQ: begin
                cmd.op     = OP_SQ;
                state_next = ST_V_SUM;
            end
            ST_V_SUM: begin
                cmd.op     = OP_SUM_V;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register frees up
                if (out_free) begin
                    cmd.op      = OP_FIN;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign m_valid = ovalid_reg;

endmodule

>>> hdl/tgp_checker.sv
// Port-level checks for the tile grid ray door probe, bound to the top level.
// Depends on tgp_pkg for widths.
module tgp_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_action,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_hit,
    input  logic [tgp_pkg::POS_W-1:0]     m_hit_x,
    input  logic [tgp_pkg::POS_W-1:0]     m_hit_y,
    input  logic [tgp_pkg::DIST_W-1:0]    m_dist_sq,
    input  logic                          m_from_horizontal,
    input  logic                          m_at_door
);
    import tgp_pkg::*;

    // a pending result is not dropped
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

    // a miss carries no distance and no door
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_dist_sq == '0) && !m_at_door && !m_from_horizontal)
        else $error("miss result carries data");

    // a door can only be seen on a hit
    a_door: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_at_door |-> m_hit)
        else $error("door flagged without a hit");

    // hits sit on a grid line of their own direction
    a_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |->
            (m_from_horizontal ? (m_hit_y[FRAC_BITS-1:0] == '0)
                               : (m_hit_x[FRAC_BITS-1:0] == '0)))
        else $error("hit point off its grid line");

    // a map write taken while idle makes no result
    a_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_action && !m_valid |=> !m_valid)
        else $error("map write produced a result");

endmodule

bind tile_grid_ray_door_probe tgp_checker u_tgp_checker (.*);

>>> verif/tile_grid_ray_door_probe_test.sv
// Self-checking bench for the tile grid ray door probe: map writes and ray casts
// are predicted in-bench and each cast result is compared field by field.
// Depends on tgp_pkg and the tile_grid_ray_door_probe top level.
module tile_grid_ray_door_probe_test;
    import tgp_pkg::*;

    localparam int  IDLE_LIMIT  = 20000;
    localparam int  SETTLE      = 400;
    localparam longint SPAN     = 16384;
    localparam longint MAP_EXT  = 524288;
    localparam longint TANG_ONE = 65536;
    localparam longint TANG_MAX = 2147483647;
    localparam longint DIST_ALL = 64'hFF_FFFF_FFFF;

    typedef struct {
        bit              hit;
        bit [POS_W-1:0]  hit_x;
        bit [POS_W-1:0]  hit_y;
        bit [DIST_W-1:0] dist_sq;
        bit              from_h;
        bit              at_door;
        bit [CELL_W-1:0] door_col;
        bit [CELL_W-1:0] door_row;
    } ray_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_action = 1'b0;
    logic [CELL_W-1:0]   s_cell_col = '0;
    logic [CELL_W-1:0]   s_cell_row = '0;
    logic [KIND_W-1:0]   s_cell_kind = '0;
    logic                s_door_valid = 1'b0;
    logic [POS_W-1:0]    s_pos_x = '0;
    logic [POS_W-1:0]    s_pos_y = '0;
    logic [ANGLE_W-1:0]  s_angle = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_hit;
    logic [POS_W-1:0]    m_hit_x;
    logic [POS_W-1:0]    m_hit_y;
    logic [DIST_W-1:0]   m_dist_sq;
    logic                m_from_horizontal;
    logic                m_at_door;
    logic [CELL_W-1:0]   m_door_col;
    logic [CELL_W-1:0]   m_door_row;
    logic                cfg_wen = 1'b0;
    logic [DR_W-1:0]     cfg_wdata = '0;

    tile_grid_ray_door_probe dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_action(s_action), .s_cell_col(s_cell_col), .s_cell_row(s_cell_row),
        .s_cell_kind(s_cell_kind), .s_door_valid(s_door_valid),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_angle(s_angle),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_hit_x(m_hit_x), .m_hit_y(m_hit_y), .m_dist_sq(m_dist_sq),
        .m_from_horizontal(m_from_horizontal), .m_at_door(m_at_door),
        .m_door_col(m_door_col), .m_door_row(m_door_row),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic [2:0]      tile_store [MAP_DEPTH];
    logic [DR_W-1:0] range_units;
    ray_result_t     pending_casts [$];
    int              errors;
    int              casts_sent, writes_sent, results_seen, hits_seen, doors_seen;
    bit              steady;
    longint          atan_steps [16] = '{2097152, 1238021, 654136, 332050, 166669,
        83416, 41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    function automatic bit on_map(longint x, longint y);
        return x >= 0 && x < MAP_EXT && y >= 0 && y < MAP_EXT;
    endfunction

    function automatic int tile_index(longint x, longint y);
        return int'((y / SPAN) * 32 + x / SPAN);
    endfunction

    function automatic bit blocks(longint x, longint y);
        logic [1:0] k;
        k = tile_store[tile_index(x, y)][1:0];
        return k == KIND_WALL || k == KIND_DOOR;
    endfunction

    function automatic longint dist_of(longint dx, longint dy);
        longint unsigned ux, uy, sum;
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        if (ux >= 64'h8000_0000 || uy >= 64'h8000_0000) return DIST_ALL;
        sum = ux * ux + uy * uy;
        return sum > DIST_ALL ? DIST_ALL : longint'(sum);
    endfunction

    function automatic ray_result_t cast_ray(logic [POS_W-1:0] pxi, logic [POS_W-1:0] pyi,
                                              logic [ANGLE_W-1:0] ang);
        ray_result_t res;
        longint px, py, x, y, z, nx, c, s, tn, xi, yi, xs, ys;
        longint hx, hy, vx, vy, hd, vd, d;
        longint unsigned un, uc, m;
        int q, i, tile_no;
        bit sat, up, right, hok, vok, use_h;
        px = pxi; py = pyi;
        q = ang[11:10];
        z = longint'(ang[9:0]) << 12;
        x = 652032874; y = 0;
        if (z == 0) begin
            x = 1073741824;
        end else begin
            for (i = 0; i < 16; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i); y = y + (x >>> i); z -= atan_steps[i];
                end else begin
                    nx = x + (y >>> i); y = y - (x >>> i); z += atan_steps[i];
                end
                x = nx;
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        un = (s < 0 ? -s : s) * TANG_ONE;
        uc = c < 0 ? -c : c;
        sat = 0;
        if (uc == 0 || un >= TANG_MAX * uc) begin
            m = TANG_MAX; sat = 1;
        end else begin
            m = un / uc;
        end
        tn = ((s < 0) != (c < 0)) ? -longint'(m) : longint'(m);
        up = ang > ANG_HALF;
        right = ang > ANG_3Q || ang < ANG_QUARTER;
        hok = 0; vok = 0; hx = 0; hy = 0; vx = 0; vy = 0;
        // horizontal grid-line crossings
        if (tn != 0) begin
            yi = (py / SPAN) * SPAN;
            if (!up) yi += SPAN;
            xi = ((yi - py) * TANG_ONE) / tn + px;
            xs = (SPAN * TANG_ONE) / tn;
            if ((!right && xs > 0) || (right && xs < 0)) xs = -xs;
            ys = up ? -SPAN : SPAN;
            if (up) yi -= 256;
            while (!hok && on_map(xi, yi)) begin
                if (blocks(xi, yi)) begin
                    hok = 1; hx = xi; hy = yi;
                end else begin
                    xi += xs; yi += ys;
                end
            end
        end
        // vertical grid-line crossings
        if (!sat) begin
            xi = (px / SPAN) * SPAN;
            if (right) xi += SPAN;
            yi = ((xi - px) * tn) / TANG_ONE + py;
            ys = (SPAN * tn) / TANG_ONE;
            if ((up && ys > 0) || (!up && ys < 0)) ys = -ys;
            xs = right ? SPAN : -SPAN;
            if (!right) xi -= 256;
            while (!vok && on_map(xi, yi)) begin
                if (blocks(xi, yi)) begin
                    vok = 1; vx = xi; vy = yi;
                end else begin
                    xi += xs; yi += ys;
                end
            end
        end
        res = '{default: 0};
        if (!hok && !vok) return res;
        hd = hok ? dist_of(hx - px, hy - py) : 0;
        vd = vok ? dist_of(vx - px, vy - py) : 0;
        use_h = hok && (!vok || hd < vd);
        x = use_h ? hx : vx;
        y = use_h ? hy : vy;
        d = use_h ? hd : vd;
        res.hit = 1;
        res.hit_x = x[POS_W-1:0];
        res.hit_y = y[POS_W-1:0];
        res.dist_sq = d[DIST_W-1:0];
        res.from_h = use_h;
        tile_no = tile_index(x, y);
        if (tile_store[tile_no][1:0] == KIND_DOOR && tile_store[tile_no][2] &&
            d < ((longint'(range_units) * range_units) << 16)) begin
            res.at_door = 1;
            res.door_col = CELL_W'(tile_no % 32);
            res.door_row = CELL_W'(tile_no / 32);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // one transaction on the input channel; predict at acceptance
    task automatic send_item(bit act, bit [CELL_W-1:0] col, bit [CELL_W-1:0] row,
                             bit [KIND_W-1:0] kind, bit dv, bit [POS_W-1:0] px,
                             bit [POS_W-1:0] py, bit [ANGLE_W-1:0] ang);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_action = act; s_cell_col = col; s_cell_row = row; s_cell_kind = kind;
        s_door_valid = dv; s_pos_x = px; s_pos_y = py; s_angle = ang;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (act) begin
            pending_casts.push_back(cast_ray(px, py, ang));
            casts_sent++;
        end else begin
            tile_store[{row, col}] = {dv, (kind == KIND_BAD) ? KIND_EMPTY : kind};
            writes_sent++;
        end
        @(negedge aclk);
    endtask

    task automatic write_cell(int col, int row, bit [KIND_W-1:0] kind, bit dv);
        send_item(1'b0, CELL_W'(col), CELL_W'(row), kind, dv, POS_W'($urandom),
                  POS_W'($urandom), ANGLE_W'($urandom));
    endtask

    task automatic cast(bit [POS_W-1:0] px, bit [POS_W-1:0] py, bit [ANGLE_W-1:0] ang);
        send_item(1'b1, CELL_W'($urandom), CELL_W'($urandom), KIND_W'($urandom),
                  1'($urandom), px, py, ang);
    endtask

    // hold the sender until the block has drained, then let any write settle
    task automatic drain;
        s_valid = 1'b0;
        while (pending_casts.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_range(bit [DR_W-1:0] value);
        drain();
        cfg_wdata = value;
        cfg_wen = 1'b1;
        @(negedge aclk);
        cfg_wen = 1'b0;
        range_units = value;
    endtask

    // result side: random stall, then accept and compare with the oldest prediction
    initial begin : result_checker
        ray_result_t want;
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
            if (pending_casts.size() == 0) begin
                report_mismatch("unexpected result transaction", 1, 0);
            end else begin
                want = pending_casts.pop_front();
                if (m_hit !== want.hit) report_mismatch("hit", m_hit, want.hit);
                if (m_hit_x !== want.hit_x) report_mismatch("hit_x", m_hit_x, want.hit_x);
                if (m_hit_y !== want.hit_y) report_mismatch("hit_y", m_hit_y, want.hit_y);
                if (m_dist_sq !== want.dist_sq)
                    report_mismatch("dist_sq", m_dist_sq, want.dist_sq);
                if (m_from_horizontal !== want.from_h)
                    report_mismatch("from_horizontal", m_from_horizontal, want.from_h);
                if (m_at_door !== want.at_door)
                    report_mismatch("at_door", m_at_door, want.at_door);
                if (m_door_col !== want.door_col)
                    report_mismatch("door_col", m_door_col, want.door_col);
                if (m_door_row !== want.door_row)
                    report_mismatch("door_row", m_door_row, want.door_row);
                hits_seen += want.hit;
                doors_seen += want.at_door;
            end
            @(negedge aclk);
        end
    end

    // watchdog: end the run when nothing moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet);
                $display("[tile_grid_ray_door_probe] ERROR");
                $finish;
            end
        end
    end

    task automatic test_directed;
        // kind three stores an empty cell; empty map gives no hit
        write_cell(5, 5, KIND_BAD, 1'b1);
        cast(19'd270336, 19'd270336, 12'd0);
        cast(19'd0, 19'd0, 12'd0);
        write_cell(31, 16, KIND_WALL, 1'b0);
        write_cell(10, 16, KIND_DOOR, 1'b1);
        write_cell(16, 10, KIND_DOOR, 1'b0);
        write_cell(0, 0, KIND_WALL, 1'b1);
        write_cell(31, 31, KIND_WALL, 1'b0);
        // axis angles (tangent zero and saturated), near-axis and diagonal angles, door casts
        cast(19'd270336, 19'd270336, 12'd0);
        cast(19'd270336, 19'd270336, 12'd1024);
        cast(19'd270336, 19'd270336, 12'd2048);
        cast(19'd270336, 19'd270336, 12'd3072);
        cast(19'd270336, 19'd270336, 12'd4095);
        cast(19'd270336, 19'd270336, 12'd1);
        cast(19'd270336, 19'd270336, 12'd512);
        cast(19'd270336, 19'd270336, 12'd1536);
        cast(19'd524287, 19'd524287, 12'd2560);
        cast(19'd0, 19'd524287, 12'd3584);
        cast(19'd155648, 19'd270336, 12'd0);
        cast(19'd155648, 19'd270336, 12'd2048);
    endtask

    task automatic test_door_range;
        set_range(12'd4095);
        cast(19'd155648, 19'd270336, 12'd0);
        cast(19'd262144, 19'd270336, 12'd2048);
        set_range(12'd0);
        cast(19'd155648, 19'd270336, 12'd0);
        set_range(12'd100);
        cast(19'd262144, 19'd270336, 12'd2048);
    endtask

    task automatic test_random;
        int i, c;
        bit [ANGLE_W-1:0] ang;
        bit [POS_W-1:0] px, py;
        // walled border so most casts stop on a tile
        for (c = 0; c < 32; c++) begin
            write_cell(c, 0, KIND_WALL, 1'($urandom));
            write_cell(c, 31, KIND_WALL, 1'($urandom));
        end
        for (c = 1; c < 31; c++) begin
            write_cell(0, c, KIND_WALL, 1'($urandom));
            write_cell(31, c, KIND_WALL, 1'($urandom));
        end
        for (i = 0; i < 800; i++) begin
            if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
            if (i == 300) set_range(12'd0);
            if (i == 450) set_range(12'd4095);
            if (i == 600) set_range(DR_W'($urandom_range(1, 4094)));
            if ($urandom_range(0, 99) < 15) begin
                c = $urandom_range(0, 9);
                write_cell($urandom, $urandom, c < 4 ? KIND_DOOR : c < 7 ? KIND_WALL :
                           c < 9 ? KIND_EMPTY : KIND_BAD, 1'($urandom));
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    px = POS_W'($urandom); py = POS_W'($urandom);
                end else begin
                    px = POS_W'($urandom_range(SPAN, MAP_EXT - SPAN - 1));
                    py = POS_W'($urandom_range(SPAN, MAP_EXT - SPAN - 1));
                end
                case ($urandom_range(0, 9))
                    0: ang = ANGLE_W'(ANG_QUARTER * $urandom_range(0, 3));
                    1: ang = ANGLE_W'(ANG_QUARTER * $urandom_range(0, 3) +
                                      $urandom_range(0, 2) - 1);
                    default: ang = ANGLE_W'($urandom);
                endcase
                cast(px, py, ang);
            end
        end
        steady = 0;
    endtask

    initial begin
        int k;
        errors = 0; casts_sent = 0; writes_sent = 0;
        results_seen = 0; hits_seen = 0; doors_seen = 0; steady = 0;
        for (k = 0; k < MAP_DEPTH; k++) tile_store[k] = '0;
        range_units = DOOR_RANGE_RST;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_door_range();
        test_random();
        s_valid = 1'b0;
        while (pending_casts.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        $display("covered %0d map writes and %0d casts: %0d hits, %0d door looks",
                 writes_sent, casts_sent, hits_seen, doors_seen);
        $display("door range swept through reset value, 0, 4095 and random settings");
        if (errors == 0 && pending_casts.size() == 0) begin
            $display("[tile_grid_ray_door_probe] OK");
        end else begin
            $display("[tile_grid_ray_door_probe] ERROR");
        end
        $finish;
    end

endmodule
